// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ECU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ECU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ecu_pkg.sv =====
package ecu_pkg;

    localparam int TIME_BITS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int CMD_BITS      = 3;
    localparam int FRAC_BITS     = 16;
    localparam int DIV_STEPS     = 2;
    localparam int DIV_STAGES    = FRAC_BITS / DIV_STEPS;
    localparam int W_BITS        = FRAC_BITS + 1;
    localparam int SQ_BITS       = 2 * W_BITS;
    localparam int CB_BITS       = 3 * W_BITS;
    localparam int F_BITS        = 2 * FRAC_BITS + 1;
    localparam int CUBE_IO_SHIFT = FRAC_BITS - 2;

    localparam logic [W_BITS-1:0] ONE_Q16 = W_BITS'(1) << FRAC_BITS;
    localparam logic [F_BITS-1:0] ONE_Q32 = F_BITS'(1) << (2 * FRAC_BITS);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_QUAD_IN     = 3'd0,
        CMD_QUAD_OUT    = 3'd1,
        CMD_QUAD_INOUT  = 3'd2,
        CMD_CUBIC_IN    = 3'd3,
        CMD_CUBIC_OUT   = 3'd4,
        CMD_CUBIC_INOUT = 3'd5
    } t_cmd;

endpackage

// ===== rtl/core/ecu_div.sv =====
module ecu_div #(
    parameter int TIME_BITS = ecu_pkg::TIME_BITS_DEF,
    parameter int SIDE_BITS = 1
) (
    input  logic                             i_clk,
    input  logic [ecu_pkg::DIV_STAGES-1:0]   i_en,
    input  logic [TIME_BITS-1:0]             i_rem,
    input  logic [TIME_BITS-1:0]             i_den,
    input  logic [SIDE_BITS-1:0]             i_side,
    output logic [ecu_pkg::FRAC_BITS-1:0]    o_quo,
    output logic [SIDE_BITS-1:0]             o_side
);
    import ecu_pkg::*;

    logic [TIME_BITS-1:0] r_rem  [DIV_STAGES];
    logic [TIME_BITS-1:0] r_den  [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_quo  [DIV_STAGES];
    logic [SIDE_BITS-1:0] r_side [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [TIME_BITS-1:0] rem_in;
        logic [TIME_BITS-1:0] den_in;
        logic [FRAC_BITS-1:0] quo_in;
        logic [SIDE_BITS-1:0] side_in;
        logic [TIME_BITS-1:0] n_rem;
        logic [FRAC_BITS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        // shift in one zero bit of the numerator per step, subtract when it fits
        always_comb begin
            logic [TIME_BITS+1:0] diff;
            n_rem = rem_in;
            n_quo = quo_in;
            for (int s = 0; s < DIV_STEPS; s++) begin
                diff = {1'b0, n_rem, 1'b0} - {2'b00, den_in};
                if (!diff[TIME_BITS+1]) begin
                    n_rem = diff[TIME_BITS-1:0];
                end else begin
                    n_rem = {n_rem[TIME_BITS-2:0], 1'b0};
                end
                n_quo = {n_quo[FRAC_BITS-2:0], ~diff[TIME_BITS+1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= den_in;
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_quo  = r_quo[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

// ===== rtl/core/easing_curve_unit.sv =====
// Throughput: one beat per cycle while o_stall is low; the 8-stage divider (two
// quotient bits per stage) and the square, cube and scale multiplier stages all pipeline.
// A stalled output holds only the unbroken run of full stages next to the output; bubbles still fill.
// Reset: synchronous, active low, clears the stage valid bits only.
`include "assert_macros.svh"

module easing_curve_unit #(
    parameter int TIME_BITS  = ecu_pkg::TIME_BITS_DEF,
    parameter int VALUE_BITS = ecu_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ecu_pkg::CMD_BITS-1:0]  i_command,
    input  logic [TIME_BITS-1:0]          i_elapsed,
    input  logic [TIME_BITS-1:0]          i_span_length,
    input  logic signed [VALUE_BITS-1:0]  i_start_value,
    input  logic signed [VALUE_BITS-1:0]  i_change_amount,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_BITS:0]    o_eased_value,
    output logic                          o_past_end,
    output logic                          o_zero_span
);
    import ecu_pkg::*;

    localparam int S_IN    = 0;
    localparam int S_W     = DIV_STAGES + 1;
    localparam int S_SQ    = DIV_STAGES + 2;
    localparam int S_CB    = DIV_STAGES + 3;
    localparam int S_F     = DIV_STAGES + 4;
    localparam int S_PROD  = DIV_STAGES + 5;
    localparam int S_OUT   = DIV_STAGES + 6;
    localparam int NUM_ST  = DIV_STAGES + 7;
    localparam int PROD_W  = VALUE_BITS + F_BITS;

    typedef struct packed {
        logic [CMD_BITS-1:0]   sel;
        logic [VALUE_BITS-1:0] start;
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic                  past;
        logic                  zero;
        logic                  full;
    } t_side;

    localparam int SIDE_BITS = $bits(t_side);

    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] n_vld;
    logic [NUM_ST-1:0] en;

    // a stage moves when the output is not stalled or it or some stage after it is empty
    always_comb begin
        for (int k = 0; k < NUM_ST; k++) begin
            en[k] = !(i_stall && ((r_vld >> k) == ({NUM_ST{1'b1}} >> k)));
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[S_IN]) begin
            n_vld[S_IN] = i_valid;
        end
        for (int k = 1; k < NUM_ST; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !en[S_IN];
    assign o_valid = r_vld[S_OUT];

    // input stage: flags and change magnitude
    logic [VALUE_BITS-1:0] chg;
    t_side                 n_in_side;
    t_side                 r_in_side;
    logic [TIME_BITS-1:0]  r_in_t;
    logic [TIME_BITS-1:0]  r_in_d;

    assign chg = i_change_amount;

    always_comb begin
        n_in_side.sel   = i_command;
        n_in_side.start = i_start_value;
        n_in_side.mag   = chg[VALUE_BITS-1] ? (~chg + 1'b1) : chg;
        n_in_side.neg   = chg[VALUE_BITS-1];
        n_in_side.past  = i_elapsed > i_span_length;
        n_in_side.zero  = i_span_length == '0;
        n_in_side.full  = i_elapsed >= i_span_length;
    end

    always_ff @(posedge i_clk) begin
        if (en[S_IN]) begin
            r_in_side <= n_in_side;
            r_in_t    <= i_elapsed;
            r_in_d    <= i_span_length;
        end
    end

    // progress u = elapsed * 2^16 / span
    logic [FRAC_BITS-1:0] div_quo;
    logic [SIDE_BITS-1:0] div_side_bits;
    t_side                div_side;

    ecu_div #(
        .TIME_BITS (TIME_BITS),
        .SIDE_BITS (SIDE_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (en[S_W-1:S_IN+1]),
        .i_rem  (r_in_t),
        .i_den  (r_in_d),
        .i_side (r_in_side),
        .o_quo  (div_quo),
        .o_side (div_side_bits)
    );

    assign div_side = t_side'(div_side_bits);

    // curve operand: u for the in curves and the first half of in-out, 1 - u otherwise
    logic              use_u;
    logic [W_BITS-1:0] n_w;
    t_side             r_w_side;
    logic [FRAC_BITS-1:0] r_w_u;
    logic [W_BITS-1:0] r_w_w;

    always_comb begin
        use_u = (div_side.sel == CMD_QUAD_IN) || (div_side.sel == CMD_CUBIC_IN)
             || (((div_side.sel == CMD_QUAD_INOUT) || (div_side.sel == CMD_CUBIC_INOUT))
                 && !div_quo[FRAC_BITS-1]);
        n_w   = use_u ? {1'b0, div_quo} : (ONE_Q16 - {1'b0, div_quo});
    end

    always_ff @(posedge i_clk) begin
        if (en[S_W]) begin
            r_w_side <= div_side;
            r_w_u    <= div_quo;
            r_w_w    <= n_w;
        end
    end

    // square
    t_side                r_sq_side;
    logic [FRAC_BITS-1:0] r_sq_u;
    logic [W_BITS-1:0]    r_sq_w;
    logic [SQ_BITS-1:0]   r_sq;

    always_ff @(posedge i_clk) begin
        if (en[S_SQ]) begin
            r_sq_side <= r_w_side;
            r_sq_u    <= r_w_u;
            r_sq_w    <= r_w_w;
            r_sq      <= SQ_BITS'(r_w_w) * SQ_BITS'(r_w_w);
        end
    end

    // cube
    t_side                r_cb_side;
    logic [FRAC_BITS-1:0] r_cb_u;
    logic [SQ_BITS-1:0]   r_cb_sq;
    logic [CB_BITS-1:0]   r_cb;

    always_ff @(posedge i_clk) begin
        if (en[S_CB]) begin
            r_cb_side <= r_sq_side;
            r_cb_u    <= r_sq_u;
            r_cb_sq   <= r_sq;
            r_cb      <= CB_BITS'(r_sq) * CB_BITS'(r_sq_w);
        end
    end

    // curve value in Q1.32
    logic [F_BITS-1:0] term;
    logic              comp;
    logic [F_BITS-1:0] n_f;
    t_side             r_f_side;
    logic [F_BITS-1:0] r_f;

    always_comb begin
        term = {1'b0, r_cb_u, {FRAC_BITS{1'b0}}};
        comp = 1'b0;
        case (r_cb_side.sel)
            CMD_QUAD_IN: begin
                term = r_cb_sq[F_BITS-1:0];
            end
            CMD_QUAD_OUT: begin
                term = r_cb_sq[F_BITS-1:0];
                comp = 1'b1;
            end
            CMD_QUAD_INOUT: begin
                term = {r_cb_sq[F_BITS-2:0], 1'b0};
                comp = r_cb_u[FRAC_BITS-1];
            end
            CMD_CUBIC_IN: begin
                term = r_cb[FRAC_BITS +: F_BITS];
            end
            CMD_CUBIC_OUT: begin
                term = r_cb[FRAC_BITS +: F_BITS];
                comp = 1'b1;
            end
            CMD_CUBIC_INOUT: begin
                term = r_cb[CUBE_IO_SHIFT +: F_BITS];
                comp = r_cb_u[FRAC_BITS-1];
            end
            default: begin
                term = {1'b0, r_cb_u, {FRAC_BITS{1'b0}}};
            end
        endcase
        if (r_cb_side.full) begin
            n_f = ONE_Q32;
        end else if (comp) begin
            n_f = ONE_Q32 - term;
        end else begin
            n_f = term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_F]) begin
            r_f_side <= r_cb_side;
            r_f      <= n_f;
        end
    end

    // scale by |change|
    t_side              r_p_side;
    logic [PROD_W-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (en[S_PROD]) begin
            r_p_side <= r_f_side;
            r_prod   <= PROD_W'(r_f_side.mag) * PROD_W'(r_f);
        end
    end

    // add to start
    logic [VALUE_BITS:0] q;
    logic [VALUE_BITS:0] start_ext;
    logic [VALUE_BITS:0] n_out;
    logic [VALUE_BITS:0] r_out_val;
    logic                r_out_past;
    logic                r_out_zero;

    always_comb begin
        q         = r_prod[2*FRAC_BITS +: VALUE_BITS+1];
        start_ext = {r_p_side.start[VALUE_BITS-1], r_p_side.start};
        n_out     = r_p_side.neg ? (start_ext - q) : (start_ext + q);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_out_val  <= n_out;
            r_out_past <= r_p_side.past;
            r_out_zero <= r_p_side.zero;
        end
    end

    assign o_eased_value = r_out_val;
    assign o_past_end    = r_out_past;
    assign o_zero_span   = r_out_zero;

    `ECU_ASSERT_IMP(a_full_sat, r_vld[S_F] && r_f_side.full, r_f == ONE_Q32, "saturated item lost f = 1.0")
    `ECU_ASSERT_IMP(a_f_range, r_vld[S_F], r_f <= ONE_Q32, "curve value above 1.0")
    `ECU_ASSERT_NXT(a_prod_hold, r_vld[S_PROD] && !en[S_PROD], r_vld[S_PROD] && $stable(r_prod), "held product stage changed")

endmodule

// ===== bench/tb_easing_curve_unit.sv =====
`timescale 1ns / 1ps

module tb_easing_curve_unit;
    import ecu_pkg::*;

    localparam int TIME_BITS    = 16;
    localparam int VALUE_BITS   = 16;
    localparam int RANDOM_BEATS = 1800;
    localparam int CHUNK_BEATS  = 100;
    localparam int LONG_HOLD    = 90;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct {
        logic [CMD_BITS-1:0]         cmd;
        logic [TIME_BITS-1:0]        elapsed;
        logic [TIME_BITS-1:0]        span;
        logic signed [VALUE_BITS-1:0] start;
        logic signed [VALUE_BITS-1:0] change;
    } t_ease_beat;

    typedef struct {
        int value;
        bit past;
        bit zero;
    } t_ease_result;

    typedef struct {
        logic [CMD_BITS-1:0] cmd;
        int                  t;
        int                  d;
        int                  s;
        int                  c;
        bit                  typed;
        int                  x_val;
        bit                  x_past;
        bit                  x_zero;
    } t_ease_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [CMD_BITS-1:0]           i_command;
    logic [TIME_BITS-1:0]          i_elapsed;
    logic [TIME_BITS-1:0]          i_span_length;
    logic signed [VALUE_BITS-1:0]  i_start_value;
    logic signed [VALUE_BITS-1:0]  i_change_amount;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [VALUE_BITS:0]    o_eased_value;
    logic                          o_past_end;
    logic                          o_zero_span;

    t_ease_result eased_expect_q[$];
    t_ease_row    dir_rows[21];
    int           mismatches;
    int           idle_pct;
    bit           long_hold;
    int unsigned  cycle_count;

    easing_curve_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_elapsed       (i_elapsed),
        .i_span_length   (i_span_length),
        .i_start_value   (i_start_value),
        .i_change_amount (i_change_amount),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_eased_value   (o_eased_value),
        .o_past_end      (o_past_end),
        .o_zero_span     (o_zero_span)
    );

    function automatic t_ease_result ease_predict(t_ease_beat b);
        longint unsigned u;
        longint unsigned v;
        longint unsigned f;
        longint unsigned mag;
        longint unsigned q;
        longint          sv;
        longint          cv;
        t_ease_result    res;
        res.past = b.elapsed > b.span;
        res.zero = b.span == 0;
        if (res.zero || b.elapsed >= b.span) begin
            f = 64'(ONE_Q32);
        end else begin
            u = {48'd0, b.elapsed};
            u = (u << FRAC_BITS) / {48'd0, b.span};
            v = ONE_Q16 - u;
            case (b.cmd)
                CMD_QUAD_IN:     f = u * u;
                CMD_QUAD_OUT:    f = u * (2 * ONE_Q16 - u);
                CMD_QUAD_INOUT:  f = (u < ONE_Q16 / 2) ? 2 * u * u : ONE_Q32 - 2 * v * v;
                CMD_CUBIC_IN:    f = (u * u * u) >> FRAC_BITS;
                CMD_CUBIC_OUT:   f = ONE_Q32 - ((v * v * v) >> FRAC_BITS);
                CMD_CUBIC_INOUT: f = (u < ONE_Q16 / 2) ? (u * u * u) >> CUBE_IO_SHIFT
                                                       : ONE_Q32 - ((v * v * v) >> CUBE_IO_SHIFT);
                default:         f = u << FRAC_BITS;
            endcase
        end
        sv = longint'(b.start);
        cv = longint'(b.change);
        mag = (cv < 0) ? longint'(-cv) : longint'(cv);
        q = (mag * f) >> (2 * FRAC_BITS);
        res.value = int'((cv < 0) ? sv - longint'(q) : sv + longint'(q));
        return res;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        logic signed [VALUE_BITS-1:0] val;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       val = VALUE_BITS'(-32768);
                1:       val = VALUE_BITS'(32767);
                2:       val = '0;
                default: val = '1;
            endcase
        end else begin
            val = VALUE_BITS'($urandom);
        end
        return val;
    endfunction

    function automatic t_ease_beat random_beat();
        t_ease_beat b;
        int         span;
        int         t;
        int         d_kind;
        int         t_kind;
        if ($urandom_range(0, 9) == 0)
            b.cmd = CMD_BITS'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else
            b.cmd = CMD_BITS'($urandom_range(CMD_QUAD_IN, CMD_CUBIC_INOUT));
        d_kind = $urandom_range(0, 19);
        if (d_kind == 0)
            span = 0;
        else if (d_kind < 4)
            span = $urandom_range(1, 16);
        else if (d_kind == 4)
            span = 65535;
        else
            span = $urandom_range(1, 65535);
        t_kind = $urandom_range(0, 19);
        if (t_kind == 0)
            t = 0;
        else if (t_kind == 1)
            t = span;
        else if (t_kind < 4)
            t = (span == 65535) ? span : $urandom_range(span + 1, 65535);
        else
            t = (span == 0) ? $urandom_range(0, 65535) : $urandom_range(0, span - 1);
        b.elapsed = TIME_BITS'(t);
        b.span    = TIME_BITS'(span);
        b.start   = pick_value();
        b.change  = pick_value();
        return b;
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(t_ease_beat b, t_ease_result res);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 8);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_command       = b.cmd;
        i_elapsed       = b.elapsed;
        i_span_length   = b.span;
        i_start_value   = b.start;
        i_change_amount = b.change;
        do @(posedge i_clk); while (o_stall);
        eased_expect_q.push_back(res);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_easing_curve_unit NOT OK");
                $finish;
            end
        end
    end

    // output side: random stall bursts, plus one long hold on request
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold = 1'b0;
                i_stall   = 1'b0;
            end else if (i_rst_n && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                burst   = $urandom_range(1, 8);
                i_stall = 1'b1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        t_ease_result got;
        t_ease_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.value = int'(o_eased_value);
                got.past  = o_past_end;
                got.zero  = o_zero_span;
                if (eased_expect_q.size() == 0) begin
                    $display("%0t: unexpected beat: value %0d past_end %0b zero_span %0b",
                             $time, got.value, got.past, got.zero);
                    mismatches++;
                end else begin
                    want = eased_expect_q.pop_front();
                    if (got.value != want.value) begin
                        $display("%0t: eased_value expected %0d actual %0d",
                                 $time, want.value, got.value);
                        mismatches++;
                    end
                    if (got.past != want.past) begin
                        $display("%0t: past_end expected %0b actual %0b",
                                 $time, want.past, got.past);
                        mismatches++;
                    end
                    if (got.zero != want.zero) begin
                        $display("%0t: zero_span expected %0b actual %0b",
                                 $time, want.zero, got.zero);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        t_ease_beat   b;
        t_ease_result res;
        int           pick;
        mismatches      = 0;
        idle_pct        = 0;
        long_hold       = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_command       = CMD_QUAD_IN;
        i_elapsed       = '0;
        i_span_length   = '0;
        i_start_value   = '0;
        i_change_amount = '0;

        dir_rows = '{
            '{CMD_QUAD_IN,         0,   100,   1000,    500, 1,   1000, 0, 0},
            '{CMD_QUAD_OUT,      100,   100,     -5,      7, 1,      2, 0, 0},
            '{CMD_QUAD_INOUT,    200,   100,     10,    -20, 1,    -10, 1, 0},
            '{CMD_CUBIC_IN,        0,     0,  32767,  32767, 1,  65534, 0, 1},
            '{CMD_CUBIC_OUT,       5,     0, -32768, -32768, 1, -65536, 1, 1},
            '{CMD_CUBIC_INOUT, 65535, 65534, -32768,  32767, 1,     -1, 1, 0},
            '{CMD_UNUSED_HI,   65535, 65535,      0, -32768, 1, -32768, 0, 0},
            '{CMD_UNUSED_LO,       0, 65535, -32768, -32768, 1, -32768, 0, 0},
            '{CMD_CUBIC_OUT,       0,     1,    123,   -456, 1,    123, 0, 0},
            '{CMD_QUAD_IN,         1,     2,      0,  32767, 0,      0, 0, 0},
            '{CMD_QUAD_OUT,        1,     3,   -100,  30000, 0,      0, 0, 0},
            '{CMD_QUAD_INOUT,  32767, 65535,      0,  32767, 0,      0, 0, 0},
            '{CMD_QUAD_INOUT,      1,     2,      0, -32768, 0,      0, 0, 0},
            '{CMD_CUBIC_IN,    65534, 65535,  32767, -32768, 0,      0, 0, 0},
            '{CMD_CUBIC_OUT,       1, 65535, -32768,  32767, 0,      0, 0, 0},
            '{CMD_CUBIC_INOUT, 32767, 65535,    100, -32768, 0,      0, 0, 0},
            '{CMD_CUBIC_INOUT,     1,     2,     -1,  32767, 0,      0, 0, 0},
            '{CMD_UNUSED_LO,       1,     2,      5,     -7, 0,      0, 0, 0},
            '{CMD_QUAD_OUT,    65534, 65535, -32768, -32768, 0,      0, 0, 0},
            '{CMD_CUBIC_IN,        3,     7,  21845, -21846, 0,      0, 0, 0},
            '{CMD_QUAD_IN,     43690, 65535, -21846,  21845, 0,      0, 0, 0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_pct = 25;
        foreach (dir_rows[k]) begin
            b.cmd     = dir_rows[k].cmd;
            b.elapsed = TIME_BITS'(dir_rows[k].t);
            b.span    = TIME_BITS'(dir_rows[k].d);
            b.start   = VALUE_BITS'(dir_rows[k].s);
            b.change  = VALUE_BITS'(dir_rows[k].c);
            if (dir_rows[k].typed) begin
                res.value = dir_rows[k].x_val;
                res.past  = dir_rows[k].x_past;
                res.zero  = dir_rows[k].x_zero;
            end else begin
                res = ease_predict(b);
            end
            send_beat(b, res);
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % CHUNK_BEATS == 0) begin
                pick = $urandom_range(0, 3);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : (pick == 2) ? 30 : 60;
                if (n == 6 * CHUNK_BEATS) begin
                    idle_pct  = 0;
                    long_hold = 1'b1;
                end
                if (n >= RANDOM_BEATS - 2 * CHUNK_BEATS)
                    idle_pct = 0;
            end
            b = random_beat();
            send_beat(b, ease_predict(b));
        end
        i_valid = 1'b0;

        while (eased_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (eased_expect_q.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, eased_expect_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb_easing_curve_unit OK");
        else
            $display("tb_easing_curve_unit NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ecu_pkg.sv
rtl/core/ecu_div.sv
rtl/core/easing_curve_unit.sv
bench/tb_easing_curve_unit.sv
